// ----- rtl/ndd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Numeric digit display updater package
// Shared widths, reset values, register indexes, payload types, controller
// states, command and status groups, and the power-of-ten table.
// ----------------------------------------------------------------------------
package ndd_pkg;

    localparam int MAX_DIGITS_DEF = 8;

    localparam int VALUE_W   = 32;
    localparam int COEF_W    = 24;
    localparam int MAXV_W    = 31;
    localparam int U_W       = 16;
    localparam int DC_W      = 4;
    localparam int DI_W      = 5;
    localparam int SLOT_W    = 3;
    localparam int DIGIT_W   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 31;
    localparam int FRAC_W    = 4;

    localparam int MAG_W      = VALUE_W - 1 + COEF_W;
    localparam int FRAC_BITS  = 24;
    localparam int HI_W       = 23;
    localparam int POW_W      = 30;
    localparam int HIP_W      = HI_W + POW_W;
    localparam int LOP_W      = FRAC_BITS + POW_W;
    localparam int RND_W      = LOP_W + 1;
    localparam int SCALED_W   = 56;
    localparam int CONV_BITS  = 8;
    localparam int CONV_STEPS = SCALED_W / CONV_BITS;
    localparam int CNT_W      = 3;
    localparam int U_SUM_W    = 20;

    localparam logic [DC_W-1:0]    RST_DIGIT_COUNT = 4'd4;
    localparam logic [DI_W-1:0]    RST_DEC_INDEX   = 5'h1F;
    localparam logic [MAXV_W-1:0]  RST_MAX_VALUE   = 31'd255974;
    localparam logic [COEF_W-1:0]  RST_COEF        = 24'd65536;
    localparam logic [U_W-1:0]     RST_U_FIRST     = 16'd78;
    localparam logic [U_W-1:0]     RST_U_STEP      = 16'd6538;
    localparam logic [U_W-1:0]     RST_U_WIDTH     = 16'd6382;
    localparam logic [DIGIT_W-1:0] UNKNOWN_DIGIT   = 4'hF;
    localparam logic [FRAC_W-1:0]  MAX_FRAC        = 4'd9;
    localparam logic [RND_W-1:0]   ROUND_HALF      = RND_W'(24'h800000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIGIT_COUNT = 3'd0,
        CFG_DEC_INDEX   = 3'd1,
        CFG_MAX_VALUE   = 3'd2,
        CFG_COEF        = 3'd3,
        CFG_U_FIRST     = 3'd4,
        CFG_U_STEP      = 3'd5,
        CFG_U_WIDTH     = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_CLAMP,
        S_SCALE,
        S_SUM,
        S_CONV,
        S_MASK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic               action;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic [SLOT_W-1:0]  digit_slot;
        logic [DIGIT_W-1:0] digit;
        logic [U_W-1:0]     u_min;
        logic [U_W-1:0]     u_max;
        logic               last;
    } t_out;

    typedef struct packed {
        logic load;
        logic prod;
        logic clamp;
        logic scale;
        logic sum;
        logic conv;
        logic mask;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic mask_empty;
        logic out_free;
    } t_sts;

    function automatic logic [POW_W-1:0] pow10(input logic [FRAC_W-1:0] f);
        logic [POW_W-1:0] p;
        case (f)
            4'd0: p = 30'd1;
            4'd1: p = 30'd10;
            4'd2: p = 30'd100;
            4'd3: p = 30'd1000;
            4'd4: p = 30'd10000;
            4'd5: p = 30'd100000;
            4'd6: p = 30'd1000000;
            4'd7: p = 30'd10000000;
            4'd8: p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

    function automatic logic [DC_W-1:0] eff_count(input logic [DC_W-1:0] c,
                                                  input logic [DC_W-1:0] max_c);
        logic [DC_W-1:0] e;
        if (c == '0) begin
            e = DC_W'(1);
        end else if (c > max_c) begin
            e = max_c;
        end else begin
            e = c;
        end
        return e;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/ndd_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Numeric digit display updater controller
// Sequences one show item through product, clamp, scale, round, conversion,
// change detection and emission of changed slots; forget items stay in idle.
// ----------------------------------------------------------------------------
module ndd_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    input  wire           i_action,
    output logic          o_in_ready,
    output ndd_pkg::t_cmd o_cmd,
    input  ndd_pkg::t_sts i_sts
);
    import ndd_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_action) begin
                    n_state = S_PROD;
                end
            end
            S_PROD:  n_state = S_CLAMP;
            S_CLAMP: n_state = S_SCALE;
            S_SCALE: n_state = S_SUM;
            S_SUM: begin
                n_state = S_CONV;
                n_cnt   = '0;
            end
            S_CONV: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(CONV_STEPS - 1)) begin
                    n_state = S_MASK;
                end
            end
            S_MASK: n_state = S_EMIT;
            S_EMIT: begin
                if (i_sts.mask_empty) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_PROD:  o_cmd.prod  = 1'b1;
            S_CLAMP: o_cmd.clamp = 1'b1;
            S_SCALE: o_cmd.scale = 1'b1;
            S_SUM:   o_cmd.sum   = 1'b1;
            S_CONV:  o_cmd.conv  = 1'b1;
            S_MASK:  o_cmd.mask  = 1'b1;
            S_EMIT:  o_cmd.emit  = !i_sts.mask_empty && i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/ndd_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Numeric digit display updater datapath
// Configuration registers, fixed-point product and scaling, binary to BCD
// conversion eight bits per cycle, shown-digit store and output register.
// ----------------------------------------------------------------------------
module ndd_dpath #(
    parameter int MAX_DIGITS = ndd_pkg::MAX_DIGITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  ndd_pkg::t_cmd                  i_cmd,
    output ndd_pkg::t_sts                  o_sts,
    input  ndd_pkg::t_in                   i_in_data,
    input  wire                            i_cfg_we,
    input  wire [ndd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [ndd_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output ndd_pkg::t_out                  o_out_data
);
    import ndd_pkg::*;

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int BCD_W = 4 * MAX_DIGITS;

    logic [DC_W-1:0]    r_dc;
    logic [DI_W-1:0]    r_di;
    logic [MAXV_W-1:0]  r_maxv;
    logic [COEF_W-1:0]  r_coef;
    logic [U_W-1:0]     r_uf;
    logic [U_W-1:0]     r_ustep;
    logic [U_W-1:0]     r_uw;

    logic [VALUE_W-1:0]  r_val;
    logic [MAG_W-1:0]    r_mag;
    logic [HIP_W-1:0]    r_hip;
    logic [LOP_W-1:0]    r_lop;
    logic [SCALED_W-1:0] r_shift;
    logic [BCD_W-1:0]    r_bcd;
    logic [MAX_DIGITS-1:0] r_mask;
    logic [DIGIT_W-1:0]  r_sdig  [MAX_DIGITS];
    logic [DIGIT_W-1:0]  r_shown [MAX_DIGITS];
    logic                r_out_valid;
    t_out                r_out;

    logic [DC_W-1:0]     eff_dc;
    logic [DC_W-1:0]     max_dc;
    logic [FRAC_W-1:0]   frac;
    logic [POW_W-1:0]    scale;
    logic [MAG_W-1:0]    limit;
    logic [RND_W-1:0]    lop_rnd;
    logic [BCD_W-1:0]    n_bcd;
    logic [SCALED_W-1:0] n_shift;
    logic [DIGIT_W-1:0]  slot_dig [MAX_DIGITS];
    logic [MAX_DIGITS-1:0] n_mask;
    logic [IDX_W-1:0]    idx;
    logic [MAX_DIGITS-1:0] low_bit;
    logic [MAX_DIGITS-1:0] rest;
    logic [DIGIT_W-1:0]  emit_dig;
    logic [U_SUM_W-1:0]  umin_raw;
    logic [U_SUM_W-1:0]  umax_raw;
    logic [SLOT_W-1:0]   slot_ext;
    logic                cfg_forget;
    logic                forget;
    logic                out_free;

    assign max_dc = DC_W'(MAX_DIGITS);
    assign eff_dc = eff_count(r_dc, max_dc);

    always_comb begin
        frac = '0;
        if (!r_di[DI_W-1] && (r_di[DI_W-2:0] < eff_dc)) begin
            frac = eff_dc - r_di[DI_W-2:0];
        end
        if (frac > MAX_FRAC) begin
            frac = MAX_FRAC;
        end
    end

    assign scale   = pow10(frac);
    assign limit   = MAG_W'({r_maxv, 16'h0000});
    assign lop_rnd = RND_W'(r_lop) + ROUND_HALF;

    always_comb begin
        n_bcd   = r_bcd;
        n_shift = r_shift;
        for (int s = 0; s < CONV_BITS; s++) begin
            for (int d = 0; d < MAX_DIGITS; d++) begin
                if (n_bcd[4*d +: 4] >= 4'd5) begin
                    n_bcd[4*d +: 4] = n_bcd[4*d +: 4] + 4'd3;
                end
            end
            n_bcd   = {n_bcd[BCD_W-2:0], n_shift[SCALED_W-1]};
            n_shift = {n_shift[SCALED_W-2:0], 1'b0};
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            slot_dig[i] = '0;
            for (int j = 0; j < MAX_DIGITS; j++) begin
                if (int'(eff_dc) - 1 - i == j) begin
                    slot_dig[i] = r_bcd[4*j +: 4];
                end
            end
            n_mask[i] = (i < int'(eff_dc)) && (slot_dig[i] != r_shown[i]);
        end
    end

    always_comb begin
        idx = '0;
        for (int i = MAX_DIGITS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                idx = IDX_W'(i);
            end
        end
    end

    assign low_bit  = r_mask & (~r_mask + MAX_DIGITS'(1));
    assign rest     = r_mask & ~low_bit;
    assign emit_dig = r_sdig[idx];
    assign umin_raw = U_SUM_W'(r_uf) + U_SUM_W'(emit_dig) * U_SUM_W'(r_ustep);
    assign umax_raw = umin_raw + U_SUM_W'(r_uw);
    assign slot_ext = SLOT_W'(idx);

    assign cfg_forget = i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_DIGIT_COUNT) &&
                        (eff_count(i_cfg_data[DC_W-1:0], max_dc) != eff_dc);
    assign forget     = (i_cmd.load && i_in_data.action) || cfg_forget;
    assign out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc    <= RST_DIGIT_COUNT;
            r_di    <= RST_DEC_INDEX;
            r_maxv  <= RST_MAX_VALUE;
            r_coef  <= RST_COEF;
            r_uf    <= RST_U_FIRST;
            r_ustep <= RST_U_STEP;
            r_uw    <= RST_U_WIDTH;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DIGIT_COUNT: r_dc    <= i_cfg_data[DC_W-1:0];
                CFG_DEC_INDEX:   r_di    <= i_cfg_data[DI_W-1:0];
                CFG_MAX_VALUE:   r_maxv  <= i_cfg_data[MAXV_W-1:0];
                CFG_COEF:        r_coef  <= i_cfg_data[COEF_W-1:0];
                CFG_U_FIRST:     r_uf    <= i_cfg_data[U_W-1:0];
                CFG_U_STEP:      r_ustep <= i_cfg_data[U_W-1:0];
                CFG_U_WIDTH:     r_uw    <= i_cfg_data[U_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val <= i_in_data.value;
        end
        if (i_cmd.prod) begin
            r_mag <= r_val[VALUE_W-1] ? '0 :
                     MAG_W'(r_val[VALUE_W-2:0]) * MAG_W'(r_coef);
        end
        if (i_cmd.clamp && (r_mag > limit)) begin
            r_mag <= limit;
        end
        if (i_cmd.scale) begin
            r_hip <= HIP_W'(r_mag[FRAC_BITS +: HI_W]) * HIP_W'(scale);
            r_lop <= LOP_W'(r_mag[FRAC_BITS-1:0]) * LOP_W'(scale);
        end
        if (i_cmd.sum) begin
            r_shift <= SCALED_W'(r_hip) + SCALED_W'(lop_rnd[RND_W-1:FRAC_BITS]);
            r_bcd   <= '0;
        end
        if (i_cmd.conv) begin
            r_shift <= n_shift;
            r_bcd   <= n_bcd;
        end
        if (i_cmd.mask) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                r_sdig[i] <= slot_dig[i];
            end
        end
        if (i_cmd.emit) begin
            r_out.digit_slot <= slot_ext;
            r_out.digit      <= emit_dig;
            r_out.u_min      <= (|umin_raw[U_SUM_W-1:U_W]) ? '1 : umin_raw[U_W-1:0];
            r_out.u_max      <= (|umax_raw[U_SUM_W-1:U_W]) ? '1 : umax_raw[U_W-1:0];
            r_out.last       <= (rest == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_DIGITS; i++) begin
                r_shown[i] <= UNKNOWN_DIGIT;
            end
        end else begin
            if (i_cmd.mask) begin
                r_mask <= n_mask;
            end else if (i_cmd.emit) begin
                r_mask <= rest;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (forget) begin
                for (int i = 0; i < MAX_DIGITS; i++) begin
                    r_shown[i] <= UNKNOWN_DIGIT;
                end
            end else if (i_cmd.emit) begin
                r_shown[idx] <= emit_dig;
            end
        end
    end

    assign o_sts.mask_empty = (r_mask == '0);
    assign o_sts.out_free   = out_free;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out;

endmodule
`default_nettype wire

// ----- rtl/numeric_digit_display_updater_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Numeric digit display updater
// Scales a fixed-point value, splits it into decimal digits and emits one
// item for every display slot whose digit changed, with its atlas U range.
// ----------------------------------------------------------------------------
//  Channel  Direction  Signals                              Handshake
//  in       input      i_in_valid, o_in_ready, i_in_data    valid/ready
//  out      output     o_out_valid, i_out_ready, o_out_data valid/ready
//  cfg      input      i_cfg_we, i_cfg_idx, i_cfg_data      write enable
//
// A show item runs through product, clamp, scale, round, conversion, change
// detection and emission of its N changed slots before the next acceptance;
// input stays ready after a forget item. Binary to BCD conversion takes
// eight bits a cycle. One changed slot leaves per cycle through the output
// register; stalls hold the emission step. Input is taken only between items.
// Synchronous reset restores the register defaults and marks all slots unknown.
module numeric_digit_display_updater_unit #(
    parameter int MAX_DIGITS = ndd_pkg::MAX_DIGITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  ndd_pkg::t_in                 i_in_data,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output ndd_pkg::t_out                o_out_data,
    input  wire                          i_cfg_we,
    input  wire [ndd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [ndd_pkg::CFG_W-1:0]     i_cfg_data
);
    import ndd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ndd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_data.action),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    ndd_dpath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// ----- rtl/ndd_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Numeric digit display updater port checker
// Watches the top-level ports for output stability, digit range, glyph range
// order and the input acceptance pattern of show and forget items.
// ----------------------------------------------------------------------------
module ndd_checker (
    input wire           i_clk,
    input wire           i_rst_n,
    input wire           i_in_valid,
    input wire           o_in_ready,
    input ndd_pkg::t_in  i_in_data,
    input wire           o_out_valid,
    input wire           i_out_ready,
    input ndd_pkg::t_out o_out_data
);
    import ndd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("Stalled output item changed.");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.digit <= 4'd9)
        else $error("Output digit is not decimal.");

    a_u_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.u_max >= o_out_data.u_min)
        else $error("Glyph right edge lies left of its left edge.");

    a_forget_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.action |=> o_in_ready)
        else $error("Forget item did not complete in one cycle.");

    a_show_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_in_data.action |=> !o_in_ready)
        else $error("Input taken while a show item is in progress.");

endmodule

bind numeric_digit_display_updater_unit ndd_checker u_ndd_checker (.*);
`default_nettype wire

// ----- tb/tb_numeric_digit_display_updater_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the numeric digit display updater
// Feeds show and forget items through the valid/ready input channel under
// several register settings and idling patterns. A built-in predictor scales,
// clamps and rounds each value, splits it into digits, tracks the digits on
// display and queues one expected item per changed slot. The monitor
// compares every output item field by field against that queue.
// ----------------------------------------------------------------------------
module tb_numeric_digit_display_updater_unit;
    import ndd_pkg::*;

    localparam int MAX_SLOTS = MAX_DIGITS_DEF;
    localparam int HOLD_AT = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 32;
    localparam longint LIMIT_NS = 5000000;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_in in_data = '0;
    logic out_ready = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int n_accepted = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    int n_mismatches = 0;

    t_in items_to_send[$];
    t_out digit_updates_due[$];
    t_out due_item;
    logic [31:0] last_value = '0;

    logic [DIGIT_W-1:0] seen_digit[MAX_SLOTS];
    logic [DC_W-1:0] cfg_count;
    logic signed [DI_W-1:0] cfg_point;
    logic [MAXV_W-1:0] cfg_ceiling;
    logic [COEF_W-1:0] cfg_gain;
    logic [U_W-1:0] cfg_u_origin;
    logic [U_W-1:0] cfg_u_pitch;
    logic [U_W-1:0] cfg_u_glyph;

    numeric_digit_display_updater_unit i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data(o_out_data),
        .i_cfg_we(cfg_we),
        .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("tb_numeric_digit_display_updater_unit NOT OK");
        $finish;
    end

    function automatic int unsigned active_slots(input logic [DC_W-1:0] c);
        if (c == 0) begin
            return 1;
        end else if (c > MAX_SLOTS) begin
            return MAX_SLOTS;
        end
        return c;
    endfunction

    task automatic forget_digits();
        for (int k = 0; k < MAX_SLOTS; k++) begin
            seen_digit[k] = UNKNOWN_DIGIT;
        end
    endtask

    task automatic reset_display_model();
        cfg_count = RST_DIGIT_COUNT;
        cfg_point = RST_DEC_INDEX;
        cfg_ceiling = RST_MAX_VALUE;
        cfg_gain = RST_COEF;
        cfg_u_origin = RST_U_FIRST;
        cfg_u_pitch = RST_U_STEP;
        cfg_u_glyph = RST_U_WIDTH;
        forget_digits();
    endtask

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] data);
        case (idx)
            CFG_DIGIT_COUNT: begin
                if (active_slots(data[DC_W-1:0]) != active_slots(cfg_count)) begin
                    forget_digits();
                end
                cfg_count = data[DC_W-1:0];
            end
            CFG_DEC_INDEX: cfg_point = data[DI_W-1:0];
            CFG_MAX_VALUE: cfg_ceiling = data[MAXV_W-1:0];
            CFG_COEF: cfg_gain = data[COEF_W-1:0];
            CFG_U_FIRST: cfg_u_origin = data[U_W-1:0];
            CFG_U_STEP: cfg_u_pitch = data[U_W-1:0];
            CFG_U_WIDTH: cfg_u_glyph = data[U_W-1:0];
            default: ;
        endcase
    endtask

    task automatic predict_digit_updates(input t_in item);
        int unsigned slots;
        int unsigned frac;
        int i;
        logic [63:0] mag;
        logic [63:0] ceiling;
        logic [63:0] scale;
        logic [63:0] scaled;
        logic [63:0] u_lo;
        logic [63:0] u_hi;
        logic [DIGIT_W-1:0] digit_of[MAX_SLOTS];
        t_out upd;
        t_out batch[$];
        if (item.action) begin
            forget_digits();
        end else begin
            slots = active_slots(cfg_count);
            frac = 0;
            if (int'(cfg_point) >= 0 && int'(cfg_point) < int'(slots)) begin
                frac = slots - int'(cfg_point);
            end
            scale = 64'd1;
            repeat (frac) scale = scale * 64'd10;
            if (item.value[31]) begin
                mag = '0;
            end else begin
                mag = 64'(item.value[30:0]) * 64'(cfg_gain);
            end
            ceiling = 64'(cfg_ceiling) << 16;
            if (mag > ceiling) begin
                mag = ceiling;
            end
            scaled = (mag >> 24) * scale
                   + (((mag & 64'hFF_FFFF) * scale + 64'h80_0000) >> 24);
            for (i = int'(slots) - 1; i >= 0; i--) begin
                digit_of[i] = DIGIT_W'(scaled % 64'd10);
                scaled = scaled / 64'd10;
            end
            for (i = 0; i < int'(slots); i++) begin
                if (digit_of[i] != seen_digit[i]) begin
                    seen_digit[i] = digit_of[i];
                    u_lo = 64'(cfg_u_origin) + 64'(digit_of[i]) * 64'(cfg_u_pitch);
                    u_hi = u_lo + 64'(cfg_u_glyph);
                    upd.digit_slot = SLOT_W'(i);
                    upd.digit = digit_of[i];
                    upd.u_min = (u_lo > 64'hFFFF) ? 16'hFFFF : u_lo[U_W-1:0];
                    upd.u_max = (u_hi > 64'hFFFF) ? 16'hFFFF : u_hi[U_W-1:0];
                    upd.last = 1'b0;
                    batch.push_back(upd);
                end
            end
            if (batch.size() > 0) begin
                batch[batch.size()-1].last = 1'b1;
            end
            foreach (batch[k]) digit_updates_due.push_back(batch[k]);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        n_mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            n_accepted <= 0;
        end else begin
            if (in_valid && o_in_ready) begin
                predict_digit_updates(in_data);
                n_accepted <= n_accepted + 1;
            end
            if (!in_valid || o_in_ready) begin
                if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data <= items_to_send.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_accepted >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (digit_updates_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected item slot %0d digit %0d",
                                              o_out_data.digit_slot, o_out_data.digit));
                end else begin
                    due_item = digit_updates_due.pop_front();
                    if (o_out_data.digit_slot != due_item.digit_slot)
                        report_mismatch($sformatf("digit_slot %0d, expected %0d",
                                                  o_out_data.digit_slot, due_item.digit_slot));
                    if (o_out_data.digit != due_item.digit)
                        report_mismatch($sformatf("digit %0d, expected %0d",
                                                  o_out_data.digit, due_item.digit));
                    if (o_out_data.u_min != due_item.u_min)
                        report_mismatch($sformatf("u_min %0d, expected %0d",
                                                  o_out_data.u_min, due_item.u_min));
                    if (o_out_data.u_max != due_item.u_max)
                        report_mismatch($sformatf("u_max %0d, expected %0d",
                                                  o_out_data.u_max, due_item.u_max));
                    if (o_out_data.last != due_item.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  o_out_data.last, due_item.last));
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        apply_register(idx, data);
    endtask

    task automatic load_setting(input logic [DC_W-1:0] count, input logic [DI_W-1:0] point,
                                input logic [MAXV_W-1:0] ceiling,
                                input logic [COEF_W-1:0] gain,
                                input logic [U_W-1:0] origin, input logic [U_W-1:0] pitch,
                                input logic [U_W-1:0] glyph);
        write_reg(CFG_DIGIT_COUNT, CFG_W'(count));
        write_reg(CFG_DEC_INDEX, CFG_W'(point));
        write_reg(CFG_MAX_VALUE, CFG_W'(ceiling));
        write_reg(CFG_COEF, CFG_W'(gain));
        write_reg(CFG_U_FIRST, CFG_W'(origin));
        write_reg(CFG_U_STEP, CFG_W'(pitch));
        write_reg(CFG_U_WIDTH, CFG_W'(glyph));
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic settle();
        do @(negedge i_clk);
        while (!(items_to_send.size() == 0 && !in_valid && digit_updates_due.size() == 0));
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] value_span();
        logic [63:0] s;
        if (cfg_gain == 0) begin
            s = 64'h7FFF_FFFF;
        end else begin
            s = (64'(cfg_ceiling) << 16) / 64'(cfg_gain);
            s = s + s / 8 + 1;
            if (s > 64'h7FFF_FFFF) s = 64'h7FFF_FFFF;
        end
        return s[31:0];
    endfunction

    function automatic t_in random_item(input logic [31:0] span);
        t_in it;
        int unsigned pick;
        logic [31:0] step;
        logic [31:0] delta;
        pick = $urandom_range(99);
        step = span / 1024 + 1;
        it.action = 1'b0;
        if (pick < 8) begin
            it.action = 1'b1;
            it.value = $urandom;
        end else if (pick < 18) begin
            it.value = $urandom;
        end else if (pick < 23) begin
            it.value = last_value;
        end else if (pick < 30) begin
            case ($urandom_range(3))
                0: it.value = span;
                1: it.value = '0;
                2: it.value = -$signed({1'b0, 8'($urandom_range(255))});
                default: it.value = 32'h7FFF_FFFF;
            endcase
        end else if (pick < 50) begin
            it.value = $urandom_range(span, 0);
        end else begin
            delta = $urandom_range(step, 0);
            it.value = $urandom_range(1) ? last_value + delta : last_value - delta;
        end
        if (!it.action) last_value = it.value;
        return it;
    endfunction

    task automatic send_random(input int n);
        logic [31:0] span;
        span = value_span();
        last_value = $urandom_range(span, 0);
        @(negedge i_clk);
        repeat (n) items_to_send.push_back(random_item(span));
    endtask

    task automatic send_show(input logic [31:0] v, input logic forget);
        t_in it;
        it.action = forget;
        it.value = v;
        items_to_send.push_back(it);
    endtask

    initial begin
        reset_display_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct <= 26;
        recv_idle_pct <= 67;

        // Directed items under the reset register values.
        @(negedge i_clk);
        send_show(32'h0000_0000, 1'b0);
        send_show(32'h0000_0000, 1'b0);
        send_show(32'd123 << 8, 1'b0);
        send_show(32'h0000_0080, 1'b0);
        send_show(32'h0000_007F, 1'b0);
        send_show(32'h7FFF_FFFF, 1'b0);
        send_show(32'h8000_0000, 1'b0);
        send_show(32'hFFFF_FFFF, 1'b0);
        send_show(32'd255974, 1'b0);
        send_show(32'd9999 << 8, 1'b0);
        send_show(32'h5A5A_5A5A, 1'b1);
        send_show(32'd9999 << 8, 1'b0);
        send_show(32'h0000_0180, 1'b0);
        send_show(32'hA5A5_A5A5, 1'b1);
        send_show(32'h0000_0000, 1'b1);
        send_show(32'd999 << 8, 1'b0);
        send_show(32'h0001_0000, 1'b0);
        settle();

        load_setting(4'd8, 5'd5, 31'h7FFF_FFFF, 24'd65536, 16'd78, 16'd6538, 16'd6382);
        send_random(60);
        settle();

        write_reg(CFG_NONE, '1);
        load_setting(4'd0, 5'd0, 31'd2559, 24'hFF_FFFF, 16'd60000, 16'hFFFF, 16'hFFFF);
        send_random(50);
        settle();

        send_idle_pct <= 67;
        recv_idle_pct <= 26;
        load_setting(4'd15, 5'd0, 31'd768, 24'd32768, 16'd0, 16'd0, 16'd0);
        send_random(50);
        settle();

        load_setting(4'd6, 5'h10, 31'd0, 24'd0, 16'd500, 16'd7000, 16'd6000);
        send_random(20);
        settle();

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        load_setting(4'd5, 5'h0F, 31'd25597400, 24'h00_A000, 16'd1000, 16'd6000, 16'd5500);
        send_random(60);
        settle();

        load_setting(4'd8, 5'd8, 31'd255974, 24'd65536, 16'd78, 16'd6538, 16'd6382);
        send_random(30);
        settle();

        load_setting(4'd4, 5'd3, 31'd255974, 24'd65536, 16'd78, 16'd6538, 16'd6382);
        send_random(30);
        settle();

        if (n_mismatches == 0) begin
            $display("tb_numeric_digit_display_updater_unit OK");
        end else begin
            $display("tb_numeric_digit_display_updater_unit NOT OK");
        end
        $finish;
    end

endmodule
